### rtl/core/fdst_pkg.sv
// ---------------------------------------------------------------------------
// fdst_pkg
// Shared types and codes for the fault delivery slot table.
// ---------------------------------------------------------------------------
package fdst_pkg;

  localparam int THREAD_BITS = 16;
  localparam int REGION_BITS = 16;
  localparam int COUNT_BITS  = 5;

  // request codes
  localparam logic [2:0] ACT_QUERY   = 3'd0;
  localparam logic [2:0] ACT_ARM     = 3'd1;
  localparam logic [2:0] ACT_TAKE    = 3'd2;
  localparam logic [2:0] ACT_ANSWER  = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;

  // result status codes
  localparam logic [2:0] STS_OK            = 3'd0;
  localparam logic [2:0] STS_INVALID       = 3'd1;
  localparam logic [2:0] STS_NOT_ARMED     = 3'd2;
  localparam logic [2:0] STS_ALREADY_ARMED = 3'd3;
  localparam logic [2:0] STS_EXHAUSTED     = 3'd4;
  localparam logic [2:0] STS_NOT_DELIVERED = 3'd5;

  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_PENDING   = 2'd1,
    SLOT_DELIVERED = 2'd2
  } slot_state_t;

  typedef struct packed {
    logic [2:0]             action;
    logic [THREAD_BITS-1:0] pager_id;
    logic [THREAD_BITS-1:0] faulting_id;
    logic [REGION_BITS-1:0] fault_region;
    logic                   fault_is_write;
    logic                   report_deliverable;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic                   is_armed;
    logic                   delivery_valid;
    logic [REGION_BITS-1:0] out_region;
    logic [THREAD_BITS-1:0] out_faulting_id;
    logic                   out_is_write;
    logic [COUNT_BITS-1:0]  occupied_count;
  } rsp_t;

  // one table entry as held in the slot RAM
  typedef struct packed {
    logic [THREAD_BITS-1:0] pager;
    logic [THREAD_BITS-1:0] faulting;
    logic [REGION_BITS-1:0] region;
    logic                   is_write;
  } slot_entry_t;

  // scan engine status toward the sequencer
  typedef struct packed {
    logic done;
    logic hit;
    logic free_hit;
  } scan_res_t;

endpackage

### rtl/core/fault_delivery_slot_table.sv
// ---------------------------------------------------------------------------
// fault_delivery_slot_table
// Pager fault delivery table: query, arm, take, answer and release requests
// against a fixed set of slots keyed by pager thread id.
// ---------------------------------------------------------------------------
// Each request passes through these steps between one req transfer and the
// next: the request is captured, the scanner reads one slot per cycle from
// the slot RAM's single read port, the RAM registers the read data, the
// scanner's registered done flag reaches the sequencer, and a commit step
// updates the table and loads the result register. The block takes one
// request at a time; req_ready is high only while the sequencer is idle.
// A finished result sits in the rsp register until transferred, and the
// next request may be accepted meanwhile; its commit waits until the rsp
// register is free. Every request scans the whole table. The invalid
// thread id register may be written at any time through
// cfg_wr_en/cfg_wr_data but is meant to change only while the block is
// idle. Slot state (free/pending/delivered) lives in flops that reset
// clears; slot contents live in RAM and are only used for occupied slots,
// so they need no clearing.
// ---------------------------------------------------------------------------
module fault_delivery_slot_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             req_valid,
  output logic                             req_ready,
  input  fdst_pkg::req_t                   req,
  // result channel
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output fdst_pkg::rsp_t                   rsp,
  // configuration: invalid thread id
  input  logic                             cfg_wr_en,
  input  logic [fdst_pkg::THREAD_BITS-1:0] cfg_wr_data
);
  import fdst_pkg::*;

  localparam int IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OW  = $clog2(SLOT_COUNT + 1);
  localparam int OXW = (OW > COUNT_BITS) ? OW : COUNT_BITS;
  localparam int EW  = $bits(slot_entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t               state;
  req_t                 cur;          // request under service
  logic [THREAD_BITS-1:0] inv_id;     // invalid thread id register
  logic [OW-1:0]        occupancy;
  slot_state_t          slot_st [SLOT_COUNT];

  // scanner hookup
  logic                 scan_start;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic [EW-1:0]        rd_word;
  slot_entry_t          rd_entry;
  logic [IW-1:0]        cmp_idx;
  slot_state_t          cmp_state;
  scan_res_t            scan_res;
  logic [IW-1:0]        hit_idx;
  slot_entry_t          hit_entry;
  slot_state_t          hit_state;
  logic [IW-1:0]        free_idx;

  // commit decision
  logic                 commit;
  logic                 found;
  rsp_t                 rsp_next;
  logic [OW-1:0]        occ_next;
  logic [OXW-1:0]       occ_ext;
  logic                 st_we;
  logic [IW-1:0]        st_idx;
  slot_state_t          st_val;
  logic                 ram_we;
  slot_entry_t          ram_wdata;

  assign req_ready  = (state == S_IDLE);
  assign scan_start = req_valid && req_ready;
  assign commit     = (state == S_COMMIT) && (!rsp_valid || rsp_ready);
  assign rd_entry   = slot_entry_t'(rd_word);
  assign cmp_state  = slot_st[cmp_idx];

  fdst_ram #(
    .WIDTH (EW),
    .DEPTH (SLOT_COUNT),
    .AW    (IW)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_we && commit),
    .wr_addr (free_idx),
    .wr_data (ram_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  fdst_scan #(
    .SLOT_COUNT (SLOT_COUNT),
    .IW         (IW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .key       (cur.pager_id),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry),
    .cmp_idx   (cmp_idx),
    .cmp_state (cmp_state),
    .res       (scan_res),
    .hit_idx   (hit_idx),
    .hit_entry (hit_entry),
    .hit_state (hit_state),
    .free_idx  (free_idx)
  );

  // Request decode, evaluated once the scan is complete. An occupied slot
  // keyed by the invalid id (possible after the id register changes) never
  // counts as a lookup hit.
  always_comb begin
    found     = scan_res.hit && (cur.pager_id != inv_id);
    rsp_next  = '{status: STS_OK, is_armed: 1'b0, delivery_valid: 1'b0,
                  out_region: '0, out_faulting_id: inv_id, out_is_write: 1'b0,
                  occupied_count: '0};
    occ_next  = occupancy;
    st_we     = 1'b0;
    st_idx    = hit_idx;
    st_val    = SLOT_FREE;
    ram_we    = 1'b0;
    ram_wdata = '{pager: cur.pager_id, faulting: cur.faulting_id,
                  region: cur.fault_region, is_write: cur.fault_is_write};

    unique case (cur.action)
      ACT_QUERY: begin
        rsp_next.is_armed = found;
      end
      ACT_ARM: begin
        if (cur.pager_id == inv_id || cur.faulting_id == inv_id ||
            cur.pager_id == cur.faulting_id) begin
          rsp_next.status = STS_INVALID;
        end else if (!cur.report_deliverable) begin
          rsp_next.status = STS_NOT_ARMED;
        end else if (found) begin
          rsp_next.status = STS_ALREADY_ARMED;
        end else if (!scan_res.free_hit) begin
          rsp_next.status = STS_EXHAUSTED;
        end else begin
          st_we    = 1'b1;
          st_idx   = free_idx;
          st_val   = SLOT_PENDING;
          ram_we   = 1'b1;
          occ_next = occupancy + 1'b1;
        end
      end
      ACT_TAKE: begin
        if (cur.pager_id == inv_id) begin
          rsp_next.status = STS_INVALID;
        end else if (!found || hit_state != SLOT_PENDING) begin
          rsp_next.status = STS_NOT_ARMED;
        end else begin
          rsp_next.delivery_valid  = 1'b1;
          rsp_next.out_region      = hit_entry.region;
          rsp_next.out_faulting_id = hit_entry.faulting;
          rsp_next.out_is_write    = hit_entry.is_write;
          st_we  = 1'b1;
          st_val = SLOT_DELIVERED;
        end
      end
      ACT_ANSWER: begin
        if (cur.pager_id == inv_id) begin
          rsp_next.status = STS_INVALID;
        end else if (!found) begin
          rsp_next.status = STS_NOT_ARMED;
        end else if (hit_state != SLOT_DELIVERED) begin
          rsp_next.status = STS_NOT_DELIVERED;
        end else begin
          rsp_next.delivery_valid  = 1'b1;
          rsp_next.out_region      = hit_entry.region;
          rsp_next.out_faulting_id = hit_entry.faulting;
          rsp_next.out_is_write    = hit_entry.is_write;
          st_we = 1'b1;
          if (occupancy != '0) begin
            occ_next = occupancy - 1'b1;
          end
        end
      end
      ACT_RELEASE: begin
        if (found) begin
          rsp_next.delivery_valid  = 1'b1;
          rsp_next.out_region      = hit_entry.region;
          rsp_next.out_faulting_id = hit_entry.faulting;
          rsp_next.out_is_write    = hit_entry.is_write;
          st_we = 1'b1;
          if (occupancy != '0) begin
            occ_next = occupancy - 1'b1;
          end
        end
      end
      default: begin
        // unused codes: no change, empty delivery
      end
    endcase

    occ_ext = OXW'(occ_next);
    rsp_next.occupied_count = occ_ext[COUNT_BITS-1:0];
  end

  // Sequencer, table state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      occupancy <= '0;
      inv_id    <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_st[i] <= SLOT_FREE;
      end
    end else begin
      if (cfg_wr_en) begin
        inv_id <= cfg_wr_data;
      end
      // a commit refills the rsp register in the cycle it drains
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (scan_start) begin
            cur   <= req;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            rsp       <= rsp_next;
            occupancy <= occ_next;
            if (st_we) begin
              slot_st[st_idx] <= st_val;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OW'(SLOT_COUNT))
    else $error("occupancy exceeds slot count");

  a_occ_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(occupancy))
    else $error("occupancy changed outside commit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    scan_start |=> !req_ready)
    else $error("request accepted while a request is in service");

  a_commit_after_scan: assert property (@(posedge clk) disable iff (rst)
    commit |-> scan_res.done)
    else $error("commit before the scan completed");

  a_armed_only_query: assert property (@(posedge clk) disable iff (rst)
    commit && rsp_next.is_armed |-> cur.action == ACT_QUERY)
    else $error("armed flag set on a non-query request");
`endif

endmodule

### rtl/core/fdst_ram.sv
// ---------------------------------------------------------------------------
// fdst_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module fdst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/fdst_scan.sv
// ---------------------------------------------------------------------------
// fdst_scan
// Slot scanner: walks the table one slot per cycle through the RAM read
// port, compares each occupied slot's pager with the key and notes the
// first hit and the first free slot.
// ---------------------------------------------------------------------------
module fdst_scan #(
  parameter int SLOT_COUNT = 16,
  parameter int IW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [fdst_pkg::THREAD_BITS-1:0]   key,
  output logic                               rd_en,
  output logic [IW-1:0]                      rd_addr,
  input  fdst_pkg::slot_entry_t              rd_entry,
  output logic [IW-1:0]                      cmp_idx,
  input  fdst_pkg::slot_state_t              cmp_state,
  output fdst_pkg::scan_res_t                res,
  output logic [IW-1:0]                      hit_idx,
  output fdst_pkg::slot_entry_t              hit_entry,
  output fdst_pkg::slot_state_t              hit_state,
  output logic [IW-1:0]                      free_idx
);
  import fdst_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  logic          issuing;
  logic [IW-1:0] issue_cnt;
  logic          cmp_vld;
  logic          done;
  logic          hit;
  logic          free_hit;
  logic          occ;
  logic          match;

  assign rd_en   = issuing;
  assign rd_addr = issue_cnt;
  assign res     = '{done: done, hit: hit, free_hit: free_hit};

  // the shared slot comparators
  assign occ   = (cmp_state != SLOT_FREE);
  assign match = (rd_entry.pager == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      cmp_vld  <= 1'b0;
      done     <= 1'b0;
      hit      <= 1'b0;
      free_hit <= 1'b0;
    end else if (start) begin
      issuing   <= 1'b1;
      issue_cnt <= '0;
      cmp_vld   <= 1'b0;
      done      <= 1'b0;
      hit       <= 1'b0;
      free_hit  <= 1'b0;
    end else begin
      cmp_vld <= issuing;
      if (issuing) begin
        cmp_idx   <= issue_cnt;
        issue_cnt <= issue_cnt + 1'b1;
        if (issue_cnt == LAST_IDX) begin
          issuing <= 1'b0;
        end
      end
      if (cmp_vld) begin
        if (occ && match && !hit) begin
          hit       <= 1'b1;
          hit_idx   <= cmp_idx;
          hit_entry <= rd_entry;
          hit_state <= cmp_state;
        end
        if (!occ && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= cmp_idx;
        end
        if (cmp_idx == LAST_IDX) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule
